### src/lcsw_pkg.sv
// Shared types and constants for the LED chaser and stopwatch timer.
// No dependencies; the core and the testbench files import this package.
package lcsw_pkg;

  localparam int unsigned PatternLengthDft = 8;

  localparam int unsigned TickIncW   = 10;
  localparam int unsigned SwPeriodW  = 16;
  localparam int unsigned PerStepW   = 14;
  localparam int unsigned AccumW     = 16;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned LedW       = 8;
  localparam int unsigned ElapsedW   = 8;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgValueW  = 16;

  localparam logic [TickIncW-1:0]  TickIncRst   = TickIncW'(33);
  localparam logic [SwPeriodW-1:0] SwPeriodRst  = SwPeriodW'(1000);
  localparam logic [PerStepW-1:0]  PerStepRst   = PerStepW'(100);
  localparam logic [PeriodW-1:0]   PatPeriodRst = PeriodW'(500);
  localparam logic [PeriodW-1:0]   PeriodMax    = PeriodW'(65000);
  localparam logic [AccumW-1:0]    AccumMax     = {AccumW{1'b1}};

  typedef enum logic [CfgIndexW-1:0] {
    REG_TICK_INCREMENT   = 2'd0,
    REG_STOPWATCH_PERIOD = 2'd1,
    REG_PERIOD_STEP      = 2'd2
  } lcsw_reg_e;

  typedef struct packed {
    logic tick;
    logic start_button;
    logic stop_button;
    logic clear_button;
    logic slower_button;
    logic faster_button;
  } lcsw_in_t;

  typedef struct packed {
    logic [LedW-1:0]     led_pattern;
    logic [ElapsedW-1:0] elapsed_count;
    logic                running;
    logic                count_changed;
  } lcsw_out_t;

  typedef struct packed {
    logic [CfgIndexW-1:0] index;
    logic [CfgValueW-1:0] value;
  } lcsw_cfg_t;

  // Chaser pattern: a bar that grows from both ends and shrinks again.
  function automatic logic [LedW-1:0] chase_entry(input logic [2:0] idx);
    logic [LedW-1:0] val;
    case (idx)
      3'd0:    val = 8'd0;
      3'd1:    val = 8'd129;
      3'd2:    val = 8'd195;
      3'd3:    val = 8'd231;
      3'd4:    val = 8'd255;
      3'd5:    val = 8'd231;
      3'd6:    val = 8'd195;
      3'd7:    val = 8'd129;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

### src/lcsw_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Payload types come from lcsw_pkg at the point of instantiation.
interface lcsw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/led_chaser_and_stopwatch_timer_core.sv
// LED chaser and stopwatch timer: one control-loop pass per input transfer.
// Depends on lcsw_pkg and lcsw_stream_if.
//
// Usage:
//   in_i  : one transfer per loop pass (tick bit and five button levels).
//   out_o : one transfer per pass (LED pattern, elapsed count, running,
//           count_changed), in input order.
//   cfg_i : register writes (index 0 tick increment, 1 stopwatch period,
//           2 period step); always ready, unknown indexes are dropped.
//           Write only while no pass is in flight.
// An input transfer is held in the input register, then one pass of
// add/compare/subtract logic writes the result register. Throughput is
// one pass per cycle while out_o does not stall; the state update of the
// pass stage is the only loop.
// When out_o stalls, the result register holds and the input register
// still takes one more transfer; in_i.ready drops only when both are full.
// Reset clears both stages and loads the register and state defaults.
module led_chaser_and_stopwatch_timer_core #(
  parameter int unsigned PatternLength = lcsw_pkg::PatternLengthDft
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcsw_stream_if.sink   in_i,
  lcsw_stream_if.source out_o,
  lcsw_stream_if.sink   cfg_i
);
  import lcsw_pkg::*;

  localparam int unsigned IdxW = $clog2(PatternLength);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PatternLength - 1);

  // Configuration registers
  logic [TickIncW-1:0]  tick_inc_q;
  logic [SwPeriodW-1:0] sw_period_q;
  logic [PerStepW-1:0]  per_step_q;

  // Pipeline registers
  logic      in_valid_q;
  lcsw_in_t  in_data_q;
  logic      out_valid_q;
  lcsw_out_t out_data_q, out_data_d;
  logic      advance;

  // Loop state
  logic [AccumW-1:0]   pat_accum_q, pat_accum_d;
  logic [IdxW-1:0]     pat_idx_q, pat_idx_d;
  logic [PeriodW-1:0]  pat_period_q, pat_period_d;
  logic [LedW-1:0]     led_q, led_d;
  logic [AccumW-1:0]   sw_accum_q, sw_accum_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                run_q, run_d;
  logic                lat_start_q, lat_start_d;
  logic                lat_stop_q, lat_stop_d;
  logic                lat_clear_q, lat_clear_d;
  logic                lat_slow_q, lat_slow_d;
  logic                lat_fast_q, lat_fast_d;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_inc_q  <= TickIncRst;
      sw_period_q <= SwPeriodRst;
      per_step_q  <= PerStepRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_TICK_INCREMENT:   tick_inc_q  <= cfg_i.data.value[TickIncW-1:0];
        REG_STOPWATCH_PERIOD: sw_period_q <= cfg_i.data.value[SwPeriodW-1:0];
        REG_PERIOD_STEP:      per_step_q  <= cfg_i.data.value[PerStepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_accum_q  <= '0;
      pat_idx_q    <= '0;
      pat_period_q <= PatPeriodRst;
      led_q        <= '0;
      sw_accum_q   <= '0;
      elapsed_q    <= '0;
      run_q        <= 1'b0;
      lat_start_q  <= 1'b0;
      lat_stop_q   <= 1'b0;
      lat_clear_q  <= 1'b0;
      lat_slow_q   <= 1'b0;
      lat_fast_q   <= 1'b0;
    end else if (advance) begin
      pat_accum_q  <= pat_accum_d;
      pat_idx_q    <= pat_idx_d;
      pat_period_q <= pat_period_d;
      led_q        <= led_d;
      sw_accum_q   <= sw_accum_d;
      elapsed_q    <= elapsed_d;
      run_q        <= run_d;
      lat_start_q  <= lat_start_d;
      lat_stop_q   <= lat_stop_d;
      lat_clear_q  <= lat_clear_d;
      lat_slow_q   <= lat_slow_d;
      lat_fast_q   <= lat_fast_d;
    end
  end

  // One loop pass
  always_comb begin
    logic [AccumW:0]    pat_sum, sw_sum, slow_sum;
    logic [AccumW-1:0]  pat_acc, sw_acc;
    logic [IdxW-1:0]    idx_next;
    logic [IdxW+2:0]    idx_ext;
    logic [PeriodW-1:0] period_s;
    logic [PerStepW:0]  two_step;
    logic               changed;

    pat_sum  = {1'b0, pat_accum_q} + (AccumW + 1)'(tick_inc_q);
    sw_sum   = {1'b0, sw_accum_q} + (AccumW + 1)'(tick_inc_q);
    pat_acc  = pat_accum_q;
    sw_acc   = sw_accum_q;
    changed  = 1'b0;
    idx_next = pat_idx_q;
    idx_ext  = '0;

    led_d        = led_q;
    pat_idx_d    = pat_idx_q;
    elapsed_d    = elapsed_q;
    run_d        = run_q;
    lat_start_d  = lat_start_q;
    lat_stop_d   = lat_stop_q;
    lat_clear_d  = lat_clear_q;

    // Saturating tick accumulation
    if (in_data_q.tick) begin
      pat_acc = pat_sum[AccumW] ? AccumMax : pat_sum[AccumW-1:0];
      if (run_q) begin
        sw_acc = sw_sum[AccumW] ? AccumMax : sw_sum[AccumW-1:0];
      end
    end

    if (pat_acc >= pat_period_q) begin
      pat_acc  = pat_acc - pat_period_q;
      idx_next = (pat_idx_q == IdxLast) ? '0 : pat_idx_q + 1'b1;
      idx_ext  = {3'b000, idx_next};
      pat_idx_d = idx_next;
      led_d     = chase_entry(idx_ext[2:0]);
    end

    if (sw_acc >= sw_period_q) begin
      sw_acc    = sw_acc - sw_period_q;
      elapsed_d = elapsed_q + 1'b1;
      changed   = 1'b1;
    end

    // Period buttons act on the press edge; the latch follows the level
    slow_sum = {1'b0, pat_period_q} + (AccumW + 1)'(per_step_q);
    period_s = pat_period_q;
    if (in_data_q.slower_button && !lat_slow_q) begin
      period_s = (slow_sum > (AccumW + 1)'(PeriodMax)) ? PeriodMax
                                                       : slow_sum[PeriodW-1:0];
    end
    lat_slow_d = in_data_q.slower_button;

    two_step     = {per_step_q, 1'b0};
    pat_period_d = period_s;
    if (in_data_q.faster_button && !lat_fast_q) begin
      pat_period_d = (period_s >= PeriodW'(two_step))
                   ? period_s - PeriodW'(per_step_q)
                   : PeriodW'(per_step_q);
    end
    lat_fast_d = in_data_q.faster_button;

    // Start, stop, clear: one action per pass, in that priority
    if (in_data_q.start_button && !lat_start_q) begin
      lat_start_d = 1'b1;
      run_d       = 1'b1;
      lat_stop_d  = 1'b0;
      lat_clear_d = 1'b0;
    end else if (in_data_q.stop_button && !lat_stop_q) begin
      lat_stop_d  = 1'b1;
      run_d       = 1'b0;
      lat_start_d = 1'b0;
    end else if (in_data_q.clear_button && !lat_clear_q) begin
      lat_clear_d = 1'b1;
      elapsed_d   = '0;
      sw_acc      = '0;
      lat_start_d = 1'b0;
      changed     = 1'b1;
    end

    pat_accum_d = pat_acc;
    sw_accum_d  = sw_acc;

    out_data_d.led_pattern   = led_d;
    out_data_d.elapsed_count = elapsed_d;
    out_data_d.running       = run_d;
    out_data_d.count_changed = changed;
  end

endmodule

### tb/lcsw_pass_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the LED chaser and stopwatch timer: it watches all three channels,
// keeps its own copy of registers and loop state, and checks each result transfer.
// Depends on lcsw_pkg.
module lcsw_pass_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lcsw_pkg::lcsw_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lcsw_pkg::lcsw_out_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  lcsw_pkg::lcsw_cfg_t cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  changes_o,
  output int                  steps_o
);
  import lcsw_pkg::*;

  // Chaser bars, entry i at bits [8*i +: 8].
  localparam logic [63:0] ChaseBars = {8'd129, 8'd195, 8'd231, 8'd255,
                                       8'd231, 8'd195, 8'd129, 8'd0};

  logic [TickIncW-1:0]  tick_inc;
  logic [SwPeriodW-1:0] sw_period;
  logic [PerStepW-1:0]  period_step;

  logic [AccumW-1:0]    pat_accum;
  logic [2:0]           pat_idx;
  logic [PeriodW-1:0]   pat_period;
  logic [LedW-1:0]      leds;
  logic [AccumW-1:0]    sw_accum;
  logic [ElapsedW-1:0]  elapsed_cnt;
  logic                 running;
  logic                 start_held, stop_held, clear_held, slower_held, faster_held;

  lcsw_out_t pass_results_q[$];

  int error_cnt = 0;
  int pending_cnt = 0;
  int checked_cnt = 0;
  int change_cnt = 0;
  int step_cnt = 0;

  assign errors_o  = error_cnt;
  assign pending_o = pending_cnt;
  assign checked_o = checked_cnt;
  assign changes_o = change_cnt;
  assign steps_o   = step_cnt;

  function automatic logic [AccumW-1:0] add_saturated(input logic [AccumW-1:0] acc);
    int sum;
    sum = int'(acc) + int'(tick_inc);
    return (sum > int'(AccumMax)) ? AccumMax : AccumW'(sum);
  endfunction

  // One loop pass: tick, chaser, stopwatch, period buttons, then start/stop/clear.
  function automatic lcsw_out_t run_loop_pass(input lcsw_in_t p);
    lcsw_out_t r;
    int sum;
    logic changed;
    changed = 1'b0;

    if (p.tick) begin
      pat_accum = add_saturated(pat_accum);
      if (running) sw_accum = add_saturated(sw_accum);
    end

    if (pat_accum >= pat_period) begin
      pat_accum = pat_accum - pat_period;
      pat_idx   = pat_idx + 3'd1;
      leds      = ChaseBars[8*pat_idx +: 8];
      step_cnt++;
    end

    if (sw_accum >= sw_period) begin
      sw_accum    = sw_accum - sw_period;
      elapsed_cnt = elapsed_cnt + 8'd1;
      changed     = 1'b1;
    end

    if (p.slower_button && !slower_held) begin
      slower_held = 1'b1;
      sum = int'(pat_period) + int'(period_step);
      pat_period = (sum > int'(PeriodMax)) ? PeriodMax : PeriodW'(sum);
    end else if (!p.slower_button && slower_held) begin
      slower_held = 1'b0;
    end

    if (p.faster_button && !faster_held) begin
      faster_held = 1'b1;
      if (int'(pat_period) >= 2 * int'(period_step)) pat_period = pat_period - period_step;
      else pat_period = PeriodW'(period_step);
    end else if (!p.faster_button && faster_held) begin
      faster_held = 1'b0;
    end

    // Start beats stop beats clear; releases never drop these latches.
    if (p.start_button && !start_held) begin
      start_held = 1'b1;
      running    = 1'b1;
      stop_held  = 1'b0;
      clear_held = 1'b0;
    end else if (p.stop_button && !stop_held) begin
      stop_held  = 1'b1;
      running    = 1'b0;
      start_held = 1'b0;
    end else if (p.clear_button && !clear_held) begin
      clear_held  = 1'b1;
      elapsed_cnt = '0;
      sw_accum    = '0;
      start_held  = 1'b0;
      changed     = 1'b1;
    end

    if (changed) change_cnt++;
    r.led_pattern   = leds;
    r.elapsed_count = elapsed_cnt;
    r.running       = running;
    r.count_changed = changed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcsw_out_t want;
    if (!rst_ni) begin
      tick_inc    = TickIncRst;
      sw_period   = SwPeriodRst;
      period_step = PerStepRst;
      pat_accum   = '0;
      pat_idx     = '0;
      pat_period  = PatPeriodRst;
      leds        = '0;
      sw_accum    = '0;
      elapsed_cnt = '0;
      running     = 1'b0;
      start_held  = 1'b0;
      stop_held   = 1'b0;
      clear_held  = 1'b0;
      slower_held = 1'b0;
      faster_held = 1'b0;
      pass_results_q.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          REG_TICK_INCREMENT:   tick_inc    = cfg_data_i.value[TickIncW-1:0];
          REG_STOPWATCH_PERIOD: sw_period   = cfg_data_i.value[SwPeriodW-1:0];
          REG_PERIOD_STEP:      period_step = cfg_data_i.value[PerStepW-1:0];
          default: ;
        endcase
      end

      // Results leave only after their pass has been registered, so pop before pushing.
      if (out_valid_i && out_ready_i) begin
        if (pass_results_q.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected result transfer, expected none, got %h", $time, out_data_i);
        end else begin
          want = pass_results_q.pop_front();
          check_field("led_pattern", want.led_pattern, out_data_i.led_pattern);
          check_field("elapsed_count", want.elapsed_count, out_data_i.elapsed_count);
          check_field("running", 8'(want.running), 8'(out_data_i.running));
          check_field("count_changed", 8'(want.count_changed), 8'(out_data_i.count_changed));
          checked_cnt++;
        end
      end

      if (in_valid_i && in_ready_i) pass_results_q.push_back(run_loop_pass(in_data_i));
      pending_cnt = pass_results_q.size();
    end
  end

endmodule

### tb/tb_led_chaser_and_stopwatch_timer_core.sv
`timescale 1ns / 1ps
// Testbench top for led_chaser_and_stopwatch_timer_core: clock, reset, pass and
// register stimulus, random back-pressure and the verdict. Depends on lcsw_pkg,
// lcsw_stream_if, the core and lcsw_pass_checker.
module tb_led_chaser_and_stopwatch_timer_core;
  import lcsw_pkg::*;

  localparam int PassesPerSetting = 160;
  localparam int NumSettings      = 8;
  localparam int StallLimit       = 5000;
  localparam int SettleCycles     = 8;
  localparam logic [CfgIndexW-1:0] CfgIdxUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   src_idle_pct = 13;
  int   sink_idle_pct = 58;
  int   quiet_cycles = 0;

  int errors, pending, checked, changes, steps;

  always #1 clk = ~clk;

  lcsw_stream_if #(.payload_t(lcsw_in_t))  pass_if ();
  lcsw_stream_if #(.payload_t(lcsw_out_t)) result_if ();
  lcsw_stream_if #(.payload_t(lcsw_cfg_t)) cfg_if ();

  led_chaser_and_stopwatch_timer_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pass_if),
    .out_o  (result_if),
    .cfg_i  (cfg_if)
  );

  lcsw_pass_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pass_if.valid),
    .in_ready_i  (pass_if.ready),
    .in_data_i   (pass_if.data),
    .out_valid_i (result_if.valid),
    .out_ready_i (result_if.ready),
    .out_data_i  (result_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .changes_o   (changes),
    .steps_o     (steps)
  );

  // Directed passes, bits {tick, start, stop, clear, slower, faster}.
  logic [5:0] directed_q[$] = '{
    6'b000000, 6'b100000, 6'b111111, 6'b011111, 6'b000000,
    6'b110000, 6'b100000, 6'b101000, 6'b110100, 6'b100100,
    6'b100000, 6'b110000, 6'b100000, 6'b110000, 6'b100010,
    6'b100010, 6'b100000, 6'b100001, 6'b100000, 6'b100001,
    6'b100000, 6'b100001, 6'b101100, 6'b100100, 6'b100000
  };

  initial begin
    pass_if.valid   = 1'b0;
    pass_if.data    = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
  end

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: any transfer on any channel resets the quiet count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pass_if.valid && pass_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_pass(input lcsw_in_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pass_if.valid <= 1'b0;
      @(negedge clk);
    end
    pass_if.valid <= 1'b1;
    pass_if.data  <= p;
    do @(posedge clk); while (!pass_if.ready);
  endtask

  // Hold off new passes until every result has come back.
  task automatic drain_passes();
    @(negedge clk);
    pass_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgValueW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CfgValueW-1:0] tick_inc,
                               input logic [CfgValueW-1:0] sw_period,
                               input logic [CfgValueW-1:0] step);
    write_reg(REG_TICK_INCREMENT, tick_inc);
    write_reg(REG_STOPWATCH_PERIOD, sw_period);
    write_reg(REG_PERIOD_STEP, step);
  endtask

  initial begin
    logic [4:0] btn_levels;
    logic       tick_bit;

    btn_levels = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_pass(lcsw_in_t'(directed_q[i]));

    for (int blk = 0; blk < NumSettings; blk++) begin
      if (blk >= 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (blk >= 3) begin
        src_idle_pct  = 58;
        sink_idle_pct = 13;
      end
      drain_passes();
      case (blk)
        0: apply_setting(16'd33, 16'd1000, 16'd100);
        1: apply_setting(16'd1, 16'd1, 16'd1);
        2: apply_setting(16'd1000, 16'd65000, 16'd10000);
        3: apply_setting(16'hFFFF, 16'd0, 16'd0);
        4: apply_setting(16'h03FF, 16'hFFFF, 16'h3FFF);
        5: apply_setting(16'($urandom_range(300, 50)), 16'($urandom_range(800, 100)),
                         16'($urandom_range(500, 1)));
        6: apply_setting(16'($urandom_range(1000, 1)), 16'($urandom_range(200, 1)),
                         16'($urandom_range(10000, 1)));
        default: begin
          write_reg(CfgIdxUnused, 16'($urandom));
          apply_setting(16'd7, 16'd20, 16'd3);
        end
      endcase

      // Buttons hold their level for a few passes; now and then scramble them all.
      for (int n = 0; n < PassesPerSetting; n++) begin
        if ($urandom_range(9) == 0) begin
          btn_levels = 5'($urandom_range(31));
        end else begin
          for (int b = 0; b < 5; b++) begin
            if ($urandom_range(3) == 0) btn_levels[b] = ~btn_levels[b];
          end
        end
        tick_bit = ($urandom_range(99) < 60);
        send_pass(lcsw_in_t'({tick_bit, btn_levels}));
      end
    end

    drain_passes();
    repeat (SettleCycles) @(posedge clk);

    $display("Checked %0d loop passes over %0d register settings and three idle profiles.",
             checked, NumSettings);
    $display("Stopwatch count changes: %0d, chaser steps: %0d.", changes, steps);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
